// ===== src/mmu_pkg.sv =====
// Shared types and constants for the translation buffer with table walk.
package mmu_pkg;

  localparam int Entries = 32;
  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = $clog2(Entries + 1);

  localparam logic [1:0] KIND_XLATE = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_INV_ALL = 2'd2;
  localparam logic [1:0] KIND_INV_ONE = 2'd3;

  localparam logic [1:0] REG_TABLE_BASE = 2'd0;
  localparam logic [1:0] REG_DOMAIN = 2'd1;
  localparam logic [1:0] REG_SYS_PROT = 2'd2;
  localparam logic [1:0] REG_ROM_PROT = 2'd3;

  localparam logic [2:0] SK_INVALID = 3'd0;
  localparam logic [2:0] SK_SMALL = 3'd1;
  localparam logic [2:0] SK_LARGE = 3'd2;
  localparam logic [2:0] SK_SECTION = 3'd3;
  localparam logic [2:0] SK_TINY = 3'd5;

  localparam logic [2:0] FLT_NONE = 3'd0;
  localparam logic [2:0] FLT_TRANS = 3'd1;
  localparam logic [2:0] FLT_DOMAIN = 3'd2;
  localparam logic [2:0] FLT_SECT_PERM = 3'd3;
  localparam logic [2:0] FLT_PAGE_PERM = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic lookup;    // register the first match of the latched address
    logic inv_all;   // clear all valid bits
    logic inv_one;   // clear the matched entry if any
    logic start_walk;// save pending request, emit level-one read
    logic reply_l1;  // process level-one descriptor
    logic reply_l2;  // process level-two descriptor
    logic emit_hit;  // emit a translation from the matched entry
    logic pop;       // output word taken
  } mmu_cmd_t;

  typedef struct packed {
    logic       found;     // registered lookup found an entry
    logic [1:0] kind;      // latched item kind
    logic       out_full;  // output register holds a word
    logic       l1_table;  // level-one reply leads to a second level read
  } mmu_sts_t;

  function automatic logic [21:0] size_mask22(input logic [2:0] sk);
    unique case (sk)
      SK_SMALL: size_mask22 = 22'h3FFFFC;
      SK_LARGE: size_mask22 = 22'h3FFFC0;
      SK_SECTION: size_mask22 = 22'h3FFC00;
      SK_TINY: size_mask22 = 22'h3FFFFF;
      default: size_mask22 = 22'h0;
    endcase
  endfunction

endpackage

// ===== src/mmu_datapath.sv =====
// Datapath: entry store, lookup, walk registers, check and output register.
module mmu_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mmu_pkg::mmu_cmd_t   cmd,
  output mmu_pkg::mmu_sts_t   sts,
  input  logic [1:0]          kind,
  input  logic [31:0]         vaddr,
  input  logic                access_is_read,
  input  logic                user_mode,
  input  logic [31:0]         descriptor,
  input  logic [17:0]         table_base,
  input  logic [31:0]         domain_access,
  input  logic                system_protect,
  input  logic                rom_protect,
  output logic                result_kind,
  output logic [31:0]         read_address,
  output logic [31:0]         paddr,
  output logic [2:0]          fault,
  output logic                fault_domain,
  output logic                hit
);
  import mmu_pkg::*;

  logic [21:0] entry_virt [Entries];
  logic [21:0] entry_phys [Entries];
  logic [7:0]  entry_perms [Entries];
  logic [3:0]  entry_domain [Entries];
  logic [2:0]  entry_sk [Entries];

  logic [IdxW-1:0] replace_pointer;
  logic [1:0]  in_kind;
  logic [31:0] in_va;
  logic        in_rd, in_user;
  logic [31:0] in_desc;
  logic [31:0] pending_virt, pending_l1;
  logic        pending_rd, pending_user;
  logic [3:0]  prev_domain;
  logic        found;
  logic [IdxW-1:0] found_idx;
  logic        out_full;

  // First-match priority search over the valid entries.
  logic            match_any;
  logic [IdxW-1:0] match_idx;
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (entry_sk[i] != SK_INVALID &&
          ((in_va[31:10] ^ entry_virt[i]) & size_mask22(entry_sk[i])) == 22'h0) begin
        match_any = 1'b1;
        match_idx = IdxW'(i);
      end
    end
  end

  // Fill decode for both walk levels.
  logic        fill_en;
  logic [2:0]  fill_sk;
  logic [31:0] fill_perm_src;
  logic [3:0]  fill_dom;
  logic [31:0] rd_addr_l2;
  logic        l2_bad;
  always_comb begin
    fill_en = 1'b0;
    fill_sk = SK_SECTION;
    fill_perm_src = in_desc & 32'h00000C0C;
    fill_dom = in_desc[8:5];
    l2_bad = 1'b0;
    if (in_desc[1:0] == 2'd1)
      rd_addr_l2 = (in_desc & 32'hFFFFFC00) | ((pending_virt & 32'h000FF000) >> 10);
    else
      rd_addr_l2 = (in_desc & 32'hFFFFF000) | ((pending_virt & 32'h000FFC00) >> 8);
    if (cmd.reply_l1) begin
      fill_en = (in_desc[1:0] == 2'd2);
    end else if (cmd.reply_l2) begin
      fill_dom = pending_l1[8:5];
      fill_perm_src = in_desc & 32'h00000FFC;
      l2_bad = (in_desc[1:0] == 2'd0) || (in_desc[1:0] == 2'd3 && pending_l1[1:0] != 2'd3);
      fill_en = !l2_bad;
      unique case (in_desc[1:0])
        2'd1: fill_sk = SK_LARGE;
        2'd2: fill_sk = SK_SMALL;
        default: fill_sk = SK_TINY;
      endcase
    end
  end

  // Check source: freshly filled values or the matched entry.
  logic [2:0]  ck_sk;
  logic [21:0] ck_phys;
  logic [7:0]  ck_perms;
  logic [3:0]  ck_dom;
  logic [31:0] ck_va;
  logic        ck_rd, ck_user;
  logic [21:0] fmask;
  always_comb begin
    fmask = size_mask22(fill_sk);
    if (fill_en) begin
      ck_sk = fill_sk;
      ck_phys = in_desc[31:10] & fmask;
      ck_perms = fill_perm_src[11:4];
      ck_dom = fill_dom;
      ck_va = pending_virt;
      ck_rd = pending_rd;
      ck_user = pending_user;
    end else begin
      ck_sk = entry_sk[found_idx];
      ck_phys = entry_phys[found_idx];
      ck_perms = entry_perms[found_idx];
      ck_dom = entry_domain[found_idx];
      ck_va = in_va;
      ck_rd = in_rd;
      ck_user = in_user;
    end
  end

  logic [1:0]  acc, sub, ap;
  logic        perm_ok;
  logic [2:0]  ck_fault;
  logic [31:0] ck_pa, pmask;
  always_comb begin
    acc = domain_access[{ck_dom, 1'b0} +: 2];
    unique case (ck_sk)
      SK_SMALL: sub = ck_va[11:10];
      SK_LARGE: sub = ck_va[15:14];
      SK_SECTION: sub = 2'd3;
      default: sub = 2'd0;
    endcase
    ap = ck_perms[{sub, 1'b0} +: 2];
    unique case (ap)
      2'd0: perm_ok = ck_rd && ((system_protect && !ck_user) || rom_protect);
      2'd1: perm_ok = !ck_user;
      2'd2: perm_ok = ck_rd || !ck_user;
      default: perm_ok = 1'b1;
    endcase
    ck_fault = FLT_NONE;
    if (acc == 2'd0 || acc == 2'd2) ck_fault = FLT_DOMAIN;
    else if (acc == 2'd1 && !perm_ok)
      ck_fault = (ck_sk == SK_SECTION) ? FLT_SECT_PERM : FLT_PAGE_PERM;
    pmask = {size_mask22(ck_sk), 10'h0};
    ck_pa = (ck_fault == FLT_NONE) ? (({ck_phys, 10'h0} & pmask) | (ck_va & ~pmask)) : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= kind;
      in_va <= vaddr;
      in_rd <= access_is_read;
      in_user <= user_mode;
      in_desc <= descriptor;
    end
    if (cmd.lookup) found_idx <= match_idx;
    if (fill_en) begin
      entry_virt[replace_pointer] <= pending_virt[31:10] & fmask;
      entry_phys[replace_pointer] <= in_desc[31:10] & fmask;
      entry_perms[replace_pointer] <= fill_perm_src[11:4];
      entry_domain[replace_pointer] <= fill_dom;
    end
    if (cmd.start_walk) begin
      pending_virt <= in_va;
      pending_rd <= in_rd;
      pending_user <= in_user;
    end
    if (cmd.reply_l1) pending_l1 <= in_desc;
    if (cmd.start_walk || cmd.reply_l1 || cmd.reply_l2 || cmd.emit_hit) begin
      result_kind <= 1'b1;
      read_address <= 32'h0;
      paddr <= 32'h0;
      fault <= FLT_TRANS;
      fault_domain <= prev_domain[0];
      hit <= 1'b0;
      if (cmd.start_walk) begin
        result_kind <= 1'b0;
        read_address <= {table_base, in_va[31:20], 2'b00};
        fault <= FLT_NONE;
        fault_domain <= 1'b0;
      end else if (cmd.reply_l1 && (in_desc[1:0] == 2'd1 || in_desc[1:0] == 2'd3)) begin
        result_kind <= 1'b0;
        read_address <= rd_addr_l2 & 32'hFFFFFFFC;
        fault <= FLT_NONE;
        fault_domain <= 1'b0;
      end else if (l2_bad) begin
        fault_domain <= pending_l1[5];
      end else if (fill_en || cmd.emit_hit) begin
        paddr <= ck_pa;
        fault <= ck_fault;
        fault_domain <= ck_dom[0];
        hit <= cmd.emit_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Entries; i++) entry_sk[i] <= SK_INVALID;
      replace_pointer <= '0;
      prev_domain <= '0;
      found <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cmd.lookup) found <= match_any;
      if (cmd.inv_all) begin
        for (int i = 0; i < Entries; i++) entry_sk[i] <= SK_INVALID;
        replace_pointer <= '0;
      end else if (cmd.inv_one && found) begin
        entry_sk[found_idx] <= SK_INVALID;
      end else if (fill_en) begin
        entry_sk[replace_pointer] <= fill_sk;
        replace_pointer <= (CntW'(replace_pointer) == CntW'(Entries - 1)) ? '0
                                                           : replace_pointer + 1'b1;
      end
      if (fill_en || cmd.emit_hit) prev_domain <= ck_dom;
      else if (l2_bad) prev_domain <= pending_l1[8:5];
      if (cmd.start_walk || cmd.reply_l1 || cmd.reply_l2 || cmd.emit_hit) out_full <= 1'b1;
      else if (cmd.pop) out_full <= 1'b0;
    end
  end

  assign sts.found = found;
  assign sts.kind = in_kind;
  assign sts.out_full = out_full;
  assign sts.l1_table = in_desc[0];
endmodule

// ===== src/mmu_ctrl.sv =====
// Controller state machine sequencing lookups, walks and result hand-off.
module mmu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  input  mmu_pkg::mmu_sts_t sts,
  output mmu_pkg::mmu_cmd_t cmd
);
  import mmu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_ACT, S_WAIT_L1, S_ACT_L1, S_WAIT_L2, S_ACT_L2
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   busy;

  // Input is taken whenever the machine is at rest; a held result only
  // delays the act step, so the next word can already be captured.
  assign in_stall = !(state == S_IDLE || state == S_WAIT_L1 || state == S_WAIT_L2);
  assign accept = in_valid && !in_stall;
  assign busy = sts.out_full && out_stall;

  always_comb begin
    cmd = '0;
    cmd.pop = sts.out_full && !out_stall;
    cmd.capture = accept;
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOOK;
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        if (!busy) begin
          state_next = S_IDLE;
          unique case (sts.kind)
            KIND_XLATE: begin
              if (sts.found) cmd.emit_hit = 1'b1;
              else begin
                cmd.start_walk = 1'b1;
                state_next = S_WAIT_L1;
              end
            end
            KIND_INV_ALL: cmd.inv_all = 1'b1;
            KIND_INV_ONE: cmd.inv_one = 1'b1;
            default: ;
          endcase
        end
      end
      S_WAIT_L1: if (accept) state_next = S_ACT_L1;
      S_ACT_L1: begin
        if (sts.kind != KIND_REPLY) state_next = S_WAIT_L1;
        else if (!busy) begin
          cmd.reply_l1 = 1'b1;
          state_next = sts.l1_table ? S_WAIT_L2 : S_IDLE;
        end
      end
      S_WAIT_L2: if (accept) state_next = S_ACT_L2;
      S_ACT_L2: begin
        if (sts.kind != KIND_REPLY) state_next = S_WAIT_L2;
        else if (!busy) begin
          cmd.reply_l2 = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== src/mmu_tlb_with_table_walk.sv =====
// Top level: translation buffer with two-level table walk.
// A word is captured when taken, the first-match search is registered on the next
// cycle and the result word is then loaded into the output register in the act step.
// A new word is not taken while the last one is in its lookup or act step.
// The act step waits only while an earlier result is held by a stalled receiver.
// Reset is synchronous and active high: entries invalid, walk idle, configuration registers zero.
module mmu_tlb_with_table_walk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] vaddr,
  input  logic        access_is_read,
  input  logic        user_mode,
  input  logic [31:0] descriptor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] read_address,
  output logic [31:0] paddr,
  output logic [2:0]  fault,
  output logic        fault_domain,
  output logic        hit
);
  import mmu_pkg::*;

  logic [17:0] table_base;
  logic [31:0] domain_access;
  logic        system_protect, rom_protect;
  mmu_cmd_t    cmd;
  mmu_sts_t    sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
      domain_access <= '0;
      system_protect <= 1'b0;
      rom_protect <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TABLE_BASE: table_base <= cfg_data[17:0];
        REG_DOMAIN: domain_access <= cfg_data;
        REG_SYS_PROT: system_protect <= cfg_data[0];
        REG_ROM_PROT: rom_protect <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid = sts.out_full;

  mmu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  mmu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kind(kind), .vaddr(vaddr), .access_is_read(access_is_read),
    .user_mode(user_mode), .descriptor(descriptor),
    .table_base(table_base), .domain_access(domain_access),
    .system_protect(system_protect), .rom_protect(rom_protect),
    .result_kind(result_kind), .read_address(read_address), .paddr(paddr),
    .fault(fault), .fault_domain(fault_domain), .hit(hit)
  );
endmodule
